@@ rtl/btst_pkg.sv @@
// btst_pkg: shared types and constants of the band trend swing tracker
// no dependencies; imported by btst_div and band_trend_swing_tracker
package btst_pkg;

  localparam int unsigned PRICE_W   = 32;
  localparam int unsigned DAYS_W    = 20;
  localparam int unsigned CFG_W     = 22;
  localparam int unsigned WTHR_W    = 22;
  localparam int unsigned DTHR_W    = 21;
  localparam int unsigned NTHR_W    = 7;
  localparam int unsigned PTHR_W    = 21;

  localparam logic [DAYS_W-1:0] DAYS_MAX      = '1;
  localparam logic [WTHR_W-1:0] WIDTH_THR_RST = WTHR_W'(655360);

  localparam logic [1:0] MODE_NEUTRAL = 2'd0;
  localparam logic [1:0] MODE_UP      = 2'd1;
  localparam logic [1:0] MODE_DOWN    = 2'd2;

  typedef enum logic [1:0] {
    CFG_WIDTH_THR = 2'd0,
    CFG_DIST_THR  = 2'd1,
    CFG_DAYS_THR  = 2'd2,
    CFG_PCT_THR   = 2'd3
  } cfg_reg_e;

  // percent request: 100 * (minu - subt) / base in q16.16
  typedef struct packed {
    logic               start;
    logic [PRICE_W-1:0] minu;
    logic [PRICE_W-1:0] subt;
    logic [PRICE_W-1:0] base;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [PRICE_W-1:0] pct;
  } div_rsp_t;

  // first member sits in the top bits, so up_days ends up lowest
  typedef struct packed {
    logic [PRICE_W-1:0] down_percent;
    logic [DAYS_W-1:0]  down_days;
    logic [PRICE_W-1:0] up_percent;
    logic [DAYS_W-1:0]  up_days;
  } result_t;

endpackage

@@ rtl/btst_div.sv @@
// btst_div: bit-serial percent unit, one quotient bit per cycle
// restoring division of 100*|diff|*2^16 by base with signed saturation; uses btst_pkg
module btst_div
  import btst_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned QW   = PRICE_W;
  localparam int unsigned CW   = $clog2(QW);
  localparam int unsigned PW   = PRICE_W + 7;
  localparam int unsigned FRAC = 16;

  typedef enum logic [5:0] {
    DV_IDLE = 6'b000001,
    DV_ABS  = 6'b000010,
    DV_MUL  = 6'b000100,
    DV_CHK  = 6'b001000,
    DV_RUN  = 6'b010000,
    DV_END  = 6'b100000
  } div_phase_e;

  div_phase_e         phase_q, phase_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [PRICE_W-1:0] a_q, b_q, base_q, mag_q, rem_q, quo_q;
  logic [PW-1:0]      prod_q;
  logic               neg_q, zero_q, sat_q;
  logic [PRICE_W:0]   trial;
  logic               trial_ge;
  logic [PRICE_W-1:0] hi_ext;
  logic               pos_big, neg_big;

  assign trial    = {rem_q, quo_q[QW-1]};
  assign trial_ge = trial >= {1'b0, base_q};
  assign hi_ext   = PRICE_W'(prod_q[PW-1:FRAC]);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    case (phase_q)
      DV_IDLE: if (req_i.start) phase_d = DV_ABS;
      DV_ABS:  phase_d = DV_MUL;
      DV_MUL:  phase_d = DV_CHK;
      DV_CHK: begin
        cnt_d   = '0;
        phase_d = DV_RUN;
      end
      DV_RUN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(QW - 1)) phase_d = DV_END;
      end
      DV_END:  phase_d = DV_IDLE;
      default: phase_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DV_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      DV_IDLE: if (req_i.start) begin
        a_q    <= req_i.minu;
        b_q    <= req_i.subt;
        base_q <= req_i.base;
      end
      DV_ABS: begin
        neg_q <= a_q < b_q;
        mag_q <= (a_q < b_q) ? (b_q - a_q) : (a_q - b_q);
      end
      DV_MUL: begin
        // times 100 as 64 + 32 + 4
        prod_q <= (PW'(mag_q) << 6) + (PW'(mag_q) << 5) + (PW'(mag_q) << 2);
        zero_q <= mag_q == '0;
      end
      DV_CHK: begin
        sat_q <= hi_ext >= base_q;
        rem_q <= hi_ext;
        quo_q <= {prod_q[FRAC-1:0], {(QW-FRAC){1'b0}}};
      end
      DV_RUN: begin
        rem_q <= trial_ge ? PRICE_W'(trial - {1'b0, base_q}) : trial[PRICE_W-1:0];
        quo_q <= {quo_q[QW-2:0], trial_ge};
      end
      default: ;
    endcase
  end

  assign pos_big = quo_q[QW-1];
  assign neg_big = quo_q[QW-1] && (|quo_q[QW-2:0]);

  always_comb begin
    rsp_o.done = phase_q == DV_END;
    if (zero_q) begin
      rsp_o.pct = '0;
    end else if (neg_q) begin
      rsp_o.pct = (sat_q || neg_big) ? {1'b1, {(QW-1){1'b0}}} : (~quo_q + PRICE_W'(1));
    end else begin
      rsp_o.pct = (sat_q || pos_big) ? {1'b0, {(QW-1){1'b1}}} : quo_q;
    end
  end

endmodule

@@ rtl/band_trend_swing_tracker.sv @@
// band_trend_swing_tracker: top level, trend state, swing registers and stream ports
// uses btst_pkg and the bit-serial percent unit btst_div
//
// One sample beat in, one result beat out. A sample whose result needs a percent
// figure passes a decision step, then the bit-serial divider (operand setup,
// times 100, range check, 32 quotient bits and a done step), then a step that
// writes the result register, and then returns to idle to take the next beat.
// Samples with no percent skip the divider and go from decision to the result
// step. The result register lets the next sample in while a result waits;
// a sample only stalls at its last step if the previous result is still held.
module band_trend_swing_tracker
  import btst_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // close_price, upper_distance, lower_distance, band_width
  input  logic [4*PRICE_W-1:0] s_axis_tdata,
  // first_of_series
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // up_days, up_percent, down_days, down_percent
  output logic [$bits(result_t)-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  localparam int unsigned IW = INDEX_BITS;
  localparam int unsigned DW = (IW > DAYS_W) ? IW : DAYS_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [WTHR_W-1:0] wthr_q;
  logic [DTHR_W-1:0] dthr_q;
  logic [NTHR_W-1:0] nthr_q;
  logic [PTHR_W-1:0] pthr_q;

  logic [1:0]         mode_q, mode_d;
  logic [PRICE_W-1:0] high_q, high_d, low_q, low_d;
  logic [IW-1:0]      hidx_q, hidx_d, lidx_q, lidx_d, sidx_q, sidx_d;
  logic               hseen_q, hseen_d, lseen_q, lseen_d;

  logic [PRICE_W-1:0] close_q, udist_q, ldist_q, bw_q;
  logic               first_q;

  logic               rep_q, rep_d, rev_q, rev_d, side_up_q, side_up_d;
  logic [IW-1:0]      days_q, days_d, cur_q, cur_d;
  logic [PRICE_W-1:0] pct_q, pct_d;

  result_t            res_q, res_d;
  logic               out_valid_q, out_valid_d;

  logic [1:0]         eff_mode;
  logic [PRICE_W-1:0] eff_high, eff_low;
  logic [IW-1:0]      eff_hidx, eff_lidx, eff_sidx;
  logic               eff_hseen, eff_lseen;
  logic [PRICE_W:0]   up_sum, lo_sum, bw_sum;
  logic               near_upper, near_lower, wide, ge_high, le_low;
  logic               fin_go, days_ok, pct_ok, rev_ok;
  logic [DW-1:0]      days_ext;
  logic [DAYS_W-1:0]  days_sat;

  div_req_t div_req;
  div_rsp_t div_rsp;

  btst_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q;
  assign cfg_ready_o   = 1'b1;

  // first_of_series restarts the state before the sample is judged
  assign eff_mode  = first_q ? MODE_NEUTRAL : mode_q;
  assign eff_high  = first_q ? '0 : high_q;
  assign eff_low   = first_q ? '0 : low_q;
  assign eff_hidx  = first_q ? '0 : hidx_q;
  assign eff_lidx  = first_q ? '0 : lidx_q;
  assign eff_sidx  = first_q ? '0 : sidx_q;
  assign eff_hseen = first_q ? 1'b0 : hseen_q;
  assign eff_lseen = first_q ? 1'b0 : lseen_q;

  assign up_sum     = {udist_q[PRICE_W-1], udist_q} + (PRICE_W+1)'(dthr_q);
  assign lo_sum     = (PRICE_W+1)'(dthr_q) - {ldist_q[PRICE_W-1], ldist_q};
  assign bw_sum     = {bw_q[PRICE_W-1], bw_q} - (PRICE_W+1)'(wthr_q);
  assign near_upper = ~up_sum[PRICE_W];
  assign near_lower = ~lo_sum[PRICE_W];
  assign wide       = ~bw_sum[PRICE_W];
  assign ge_high    = close_q >= eff_high;
  assign le_low     = close_q <= eff_low;

  assign fin_go   = !out_valid_q || m_axis_tready;
  assign days_ok  = days_q >= IW'(nthr_q);
  assign pct_ok   = $signed(pct_q) >= $signed(PRICE_W'(pthr_q));
  assign rev_ok   = rev_q && days_ok && pct_ok;
  assign days_ext = DW'(days_q);
  assign days_sat = (days_ext > DW'(DAYS_MAX)) ? DAYS_MAX : days_ext[DAYS_W-1:0];

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    high_d      = high_q;
    low_d       = low_q;
    hidx_d      = hidx_q;
    lidx_d      = lidx_q;
    sidx_d      = sidx_q;
    hseen_d     = hseen_q;
    lseen_d     = lseen_q;
    rep_d       = rep_q;
    rev_d       = rev_q;
    side_up_d   = side_up_q;
    days_d      = days_q;
    cur_d       = cur_q;
    pct_d       = pct_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    div_req     = '0;

    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_PREP;

      ST_PREP: begin
        mode_d    = eff_mode;
        high_d    = eff_high;
        low_d     = eff_low;
        hidx_d    = eff_hidx;
        lidx_d    = eff_lidx;
        hseen_d   = eff_hseen;
        lseen_d   = eff_lseen;
        sidx_d    = (eff_sidx != '1) ? eff_sidx + IW'(1) : eff_sidx;
        cur_d     = eff_sidx;
        rep_d     = 1'b0;
        rev_d     = 1'b0;
        side_up_d = 1'b0;
        days_d    = '0;
        if (eff_mode == MODE_UP) begin
          if (ge_high || near_upper) begin
            if (ge_high) begin
              high_d  = close_q;
              hidx_d  = eff_sidx;
              hseen_d = 1'b1;
            end
            if (eff_lseen) begin
              rep_d     = 1'b1;
              side_up_d = 1'b1;
              days_d    = eff_sidx - eff_lidx;
            end
          end else if (near_lower && wide) begin
            rev_d  = 1'b1;
            days_d = eff_sidx - eff_hidx;
          end
        end else if (eff_mode == MODE_DOWN) begin
          if (le_low || near_lower) begin
            if (le_low) begin
              low_d   = close_q;
              lidx_d  = eff_sidx;
              lseen_d = 1'b1;
            end
            if (eff_hseen) begin
              rep_d  = 1'b1;
              days_d = eff_sidx - eff_hidx;
            end
          end else if (near_upper && wide) begin
            rev_d     = 1'b1;
            side_up_d = 1'b1;
            days_d    = eff_sidx - eff_lidx;
          end
        end else begin
          if (near_upper && wide) begin
            high_d  = close_q;
            hidx_d  = eff_sidx;
            hseen_d = 1'b1;
            mode_d  = MODE_UP;
          end else if (near_lower && wide) begin
            low_d   = close_q;
            lidx_d  = eff_sidx;
            lseen_d = 1'b1;
            mode_d  = MODE_DOWN;
          end
        end
        div_req.start = rep_d || rev_d;
        if (side_up_d) begin
          div_req.minu = close_q;
          div_req.subt = eff_low;
          div_req.base = eff_low;
        end else begin
          div_req.minu = eff_high;
          div_req.subt = close_q;
          div_req.base = eff_high;
        end
        state_d = (rep_d || rev_d) ? ST_DIV : ST_FIN;
      end

      ST_DIV: if (div_rsp.done) begin
        pct_d   = div_rsp.pct;
        state_d = ST_FIN;
      end

      ST_FIN: if (fin_go) begin
        res_d       = '0;
        out_valid_d = 1'b1;
        if (rep_q || rev_ok) begin
          if (side_up_q) begin
            res_d.up_days    = days_sat;
            res_d.up_percent = pct_q;
          end else begin
            res_d.down_days    = days_sat;
            res_d.down_percent = pct_q;
          end
        end
        if (rev_ok) begin
          if (side_up_q) begin
            high_d  = close_q;
            hidx_d  = cur_q;
            hseen_d = 1'b1;
            mode_d  = MODE_UP;
          end else begin
            low_d   = close_q;
            lidx_d  = cur_q;
            lseen_d = 1'b1;
            mode_d  = MODE_DOWN;
          end
        end
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_NEUTRAL;
      high_q      <= '0;
      low_q       <= '0;
      hidx_q      <= '0;
      lidx_q      <= '0;
      sidx_q      <= '0;
      hseen_q     <= 1'b0;
      lseen_q     <= 1'b0;
      rep_q       <= 1'b0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
      wthr_q      <= WIDTH_THR_RST;
      dthr_q      <= '0;
      nthr_q      <= '0;
      pthr_q      <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      high_q      <= high_d;
      low_q       <= low_d;
      hidx_q      <= hidx_d;
      lidx_q      <= lidx_d;
      sidx_q      <= sidx_d;
      hseen_q     <= hseen_d;
      lseen_q     <= lseen_d;
      rep_q       <= rep_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_WIDTH_THR: wthr_q <= cfg_data_i[WTHR_W-1:0];
          CFG_DIST_THR:  dthr_q <= cfg_data_i[DTHR_W-1:0];
          CFG_DAYS_THR:  nthr_q <= cfg_data_i[NTHR_W-1:0];
          CFG_PCT_THR:   pthr_q <= cfg_data_i[PTHR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      close_q <= s_axis_tdata[PRICE_W-1:0];
      udist_q <= s_axis_tdata[2*PRICE_W-1:PRICE_W];
      ldist_q <= s_axis_tdata[3*PRICE_W-1:2*PRICE_W];
      bw_q    <= s_axis_tdata[4*PRICE_W-1:3*PRICE_W];
      first_q <= s_axis_tuser;
    end
    side_up_q <= side_up_d;
    days_q    <= days_d;
    cur_q     <= cur_d;
    pct_q     <= pct_d;
    res_q     <= res_d;
  end

`ifndef SYNTH
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("percent unit finished outside the divide wait");

  a_mode_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_NEUTRAL || mode_q == MODE_UP || mode_q == MODE_DOWN)
    else $error("trend mode holds the unused code");

  a_idx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hidx_q <= sidx_q && lidx_q <= sidx_q)
    else $error("swing index ahead of sample index");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && fin_go) |=> m_axis_tvalid)
    else $error("finished sample left no result beat");
`endif

endmodule
